// ===== hw/rtl/tns_pkg.sv =====
`default_nettype none

package tns_pkg;

    typedef logic [31:0] t_word;

    // input modes
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_READOUT = 1'b1;

    localparam int CFG_W     = 5;
    localparam int RESET_LEN = 16;

    typedef struct packed {
        logic  mode;
        t_word key_tag;
        t_word score;
    } t_tns_in;

    typedef struct packed {
        t_word rank_key;
        t_word rank_score;
        logic  occupied;
        logic  final_rank;
    } t_tns_out;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic start;
        logic emit;
    } t_tns_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_tns_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_tns_state;

endpackage

`default_nettype wire

// ===== hw/rtl/top_n_insertion_selector.sv =====
`default_nettype none

// channel   direction  handshake                  payload
// in        request    i_in_valid / o_in_ready    i_in  (mode, key_tag, score)
// out       result     o_out_valid / i_out_ready  o_out (rank_key, rank_score,
//                                                        occupied, final_rank)
// cfg       write      i_cfg_we                   i_cfg_wdata (list_length)
//
// an insert is applied at the edge that accepts it: every slot compares against the new score
// in parallel and the chain shifts below the insertion point in the same edge
// a readout takes the request, then emits the ranks in order, stalling while the
// output register is full; slot 0 feeds the output register and the first N slots
// rotate, so the list is back in place after the final rank
// synchronous active-low reset empties the list and sets N to 16 (or MAX_LIST)
// the last result may wait in the output register while the next request is taken

module top_n_insertion_selector #(
    parameter int MAX_LIST = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire  [tns_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  tns_pkg::t_tns_in           i_in,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output tns_pkg::t_tns_out          o_out
);

    tns_pkg::t_tns_cmd    cmd;
    tns_pkg::t_tns_status status;

    // sequencing of requests and the output valid flag
    tns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_in.mode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // ranked slots, fill count, list length and output register
    tns_dpath #(
        .MAX_LIST (MAX_LIST)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

    // no new request is taken while a readout is still emitting
    a_no_accept_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !o_in_ready)
        else $error("request accepted during readout");

    // a readout start leaves idle, so the request port goes busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !o_in_ready)
        else $error("readout start did not leave idle");

    // emitting the final rank returns to idle and marks the result
    a_final_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && status.last) |=> (o_in_ready && o_out_valid && o_out.final_rank))
        else $error("final rank not flagged or controller stuck");

    // an empty rank reports zero key and score
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.occupied) |-> (o_out.rank_key == '0 && o_out.rank_score == '0))
        else $error("empty rank carries data");

endmodule

`default_nettype wire

// ===== hw/rtl/tns_ctrl.sv =====
`default_nettype none

module tns_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_mode,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tns_pkg::t_tns_cmd    o_cmd,
    input  tns_pkg::t_tns_status i_status
);

    tns_pkg::t_tns_state r_state;
    tns_pkg::t_tns_state n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tns_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tns_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_mode == tns_pkg::MODE_INSERT) begin
                        o_cmd.insert = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = tns_pkg::S_READ;
                    end
                end
            end
            tns_pkg::S_READ: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = tns_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = tns_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/tns_dpath.sv =====
`default_nettype none

module tns_dpath #(
    parameter int MAX_LIST = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [tns_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  tns_pkg::t_tns_in               i_in,
    input  tns_pkg::t_tns_cmd              i_cmd,
    output tns_pkg::t_tns_status           o_status,
    output tns_pkg::t_tns_out              o_out
);

    localparam int LW      = $clog2(MAX_LIST + 1);
    localparam int IW      = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
    localparam int RST_LEN = (MAX_LIST < tns_pkg::RESET_LEN) ? MAX_LIST : tns_pkg::RESET_LEN;

    tns_pkg::t_word    r_key   [MAX_LIST];
    tns_pkg::t_word    r_score [MAX_LIST];
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     n_len;
    logic [LW-1:0]     r_fill;
    logic [IW-1:0]     r_rank;
    logic [MAX_LIST-1:0] ge;
    logic [MAX_LIST-1:0] in_win;
    logic              occ;
    tns_pkg::t_tns_out r_out;

    // clamp the written length into 1..MAX_LIST
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_len = LW'(1);
        end else if (32'(i_cfg_wdata) > 32'(MAX_LIST)) begin
            n_len = LW'(MAX_LIST);
        end else begin
            n_len = LW'(i_cfg_wdata);
        end
    end

    // per slot: held and ranked at or above the newcomer
    always_comb begin
        for (int i = 0; i < MAX_LIST; i++) begin
            ge[i]     = (LW'(i) < r_fill) && (r_score[i] >= i_in.score);
            in_win[i] = LW'(i) < r_len;
        end
    end

    // compare-and-shift chain; readout rotates the window of N slots
    for (genvar g = 0; g < MAX_LIST; g++) begin : g_slot
        logic           ins_here;
        logic           shift_in;
        tns_pkg::t_word rot_key;
        tns_pkg::t_word rot_score;

        if (g == 0) begin : g_head
            assign ins_here = !ge[0];
            assign shift_in = 1'b0;
        end else begin : g_body
            assign ins_here = !ge[g] && ge[g-1];
            assign shift_in = !ge[g] && !ge[g-1];
        end

        if (g == MAX_LIST - 1) begin : g_tail
            assign rot_key   = r_key[0];
            assign rot_score = r_score[0];
        end else begin : g_mid
            assign rot_key   = (LW'(g + 1) == r_len) ? r_key[0]   : r_key[g+1];
            assign rot_score = (LW'(g + 1) == r_len) ? r_score[0] : r_score[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (in_win[g]) begin
                if (i_cmd.insert && ins_here) begin
                    r_key[g]   <= i_in.key_tag;
                    r_score[g] <= i_in.score;
                end else if (i_cmd.insert && shift_in) begin
                    r_key[g]   <= r_key[(g > 0) ? g - 1 : 0];
                    r_score[g] <= r_score[(g > 0) ? g - 1 : 0];
                end else if (i_cmd.emit) begin
                    r_key[g]   <= rot_key;
                    r_score[g] <= rot_score;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LW'(RST_LEN);
            r_fill <= '0;
            r_rank <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len <= n_len;
                if (r_fill > n_len) begin
                    r_fill <= n_len;
                end
            end else if (i_cmd.insert && (r_fill < r_len)) begin
                r_fill <= r_fill + LW'(1);
            end
            if (i_cmd.start) begin
                r_rank <= '0;
            end else if (i_cmd.emit) begin
                r_rank <= r_rank + IW'(1);
            end
        end
    end

    assign occ           = LW'(r_rank) < r_fill;
    assign o_status.last = LW'(r_rank) == (r_len - LW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.rank_key   <= occ ? r_key[0]   : '0;
            r_out.rank_score <= occ ? r_score[0] : '0;
            r_out.occupied   <= occ;
            r_out.final_rank <= o_status.last;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== test/tb_top_n_insertion_selector.sv =====
`default_nettype none

module tb_top_n_insertion_selector;

    localparam int MAX_RANKS = 16;

    // clock, reset and stimulus, all known from time zero
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [tns_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic                      i_in_valid  = 1'b0;
    tns_pkg::t_tns_in          i_in        = '0;
    logic                      i_out_ready = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    tns_pkg::t_tns_out         o_out;

    // shadow of the ranked list, updated as each request is accepted
    int unsigned    rank_len;
    int unsigned    held_count;
    tns_pkg::t_word held_keys   [MAX_RANKS];
    tns_pkg::t_word held_scores [MAX_RANKS];

    // ranks still owed by the block, oldest first
    tns_pkg::t_tns_out owed_ranks [$];

    int unsigned mismatch_count = 0;
    bit          no_idle        = 1'b0;

    top_n_insertion_selector #(
        .MAX_LIST    (MAX_RANKS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // ranking shadow
    // ---------------------------------------------------------------

    function automatic void shadow_reset();
        int unsigned i;
        for (i = 0; i < MAX_RANKS; i++) begin
            held_keys[i]   = '0;
            held_scores[i] = '0;
        end
        held_count = 0;
        rank_len   = tns_pkg::RESET_LEN;
    endfunction

    // out-of-range lengths saturate, and a shorter list loses its tail for good
    function automatic void shadow_length(logic [tns_pkg::CFG_W-1:0] raw);
        if (raw == 0) begin
            rank_len = 1;
        end else if (raw > MAX_RANKS) begin
            rank_len = MAX_RANKS;
        end else begin
            rank_len = 32'(raw);
        end
        if (held_count > rank_len) begin
            held_count = rank_len;
        end
    endfunction

    // new pair sits just below every held score that is greater or equal,
    // so ties keep arrival order; on a full list the tail entry drops out
    function automatic void shadow_insert(tns_pkg::t_word key, tns_pkg::t_word sc);
        int unsigned pos;
        int unsigned tail;
        int unsigned i;
        pos = 0;
        while (pos < held_count && held_scores[pos] >= sc) begin
            pos++;
        end
        if (pos >= rank_len) begin
            return;
        end
        tail = (held_count < rank_len) ? held_count : rank_len - 1;
        for (i = tail; i > pos; i--) begin
            held_keys[i]   = held_keys[i - 1];
            held_scores[i] = held_scores[i - 1];
        end
        held_keys[pos]   = key;
        held_scores[pos] = sc;
        if (held_count < rank_len) begin
            held_count++;
        end
    endfunction

    // a readout owes one result per rank, empty ranks reading as zero
    function automatic void shadow_readout();
        tns_pkg::t_tns_out r;
        int unsigned       i;
        for (i = 0; i < rank_len; i++) begin
            r.occupied   = (i < held_count);
            r.rank_key   = r.occupied ? held_keys[i] : '0;
            r.rank_score = r.occupied ? held_scores[i] : '0;
            r.final_rank = (i + 1 == rank_len);
            owed_ranks.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // receiver back-pressure, switched off during steady phases
    always @(negedge i_clk) begin
        if (no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 23);
        end
    end

    // every accepted result is matched against the oldest owed rank
    always @(posedge i_clk) begin
        tns_pkg::t_tns_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_ranks.size() == 0) begin
                $error("unexpected result: key %h score %h occupied %b final %b",
                       o_out.rank_key, o_out.rank_score, o_out.occupied,
                       o_out.final_rank);
                mismatch_count++;
            end else begin
                want = owed_ranks.pop_front();
                if (o_out.rank_key !== want.rank_key) begin
                    $error("rank_key: expected %h, got %h", want.rank_key,
                           o_out.rank_key);
                    mismatch_count++;
                end
                if (o_out.rank_score !== want.rank_score) begin
                    $error("rank_score: expected %h, got %h", want.rank_score,
                           o_out.rank_score);
                    mismatch_count++;
                end
                if (o_out.occupied !== want.occupied) begin
                    $error("occupied: expected %b, got %b", want.occupied,
                           o_out.occupied);
                    mismatch_count++;
                end
                if (o_out.final_rank !== want.final_rank) begin
                    $error("final_rank: expected %b, got %b", want.final_rank,
                           o_out.final_rank);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // one request: optional random gap with junk payload, then hold valid
    // until the handshake, and update the shadow at the accepting edge
    task automatic send_request(input logic md, input tns_pkg::t_word key,
                                input tns_pkg::t_word sc);
        tns_pkg::t_tns_in req;
        req.mode    = md;
        req.key_tag = key;
        req.score   = sc;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            i_in       <= {1'($urandom), 32'($urandom), 32'($urandom)};
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (md == tns_pkg::MODE_INSERT) begin
            shadow_insert(key, sc);
        end else begin
            shadow_readout();
        end
    endtask

    task automatic send_insert(input tns_pkg::t_word key, input tns_pkg::t_word sc);
        send_request(tns_pkg::MODE_INSERT, key, sc);
    endtask

    // readout ignores key and score, so they carry noise
    task automatic send_readout();
        send_request(tns_pkg::MODE_READOUT, $urandom, $urandom);
    endtask

    // length changes only with the block quiet: request line dropped straight
    // after the last handshake, all ranks delivered and a settling wait
    task automatic write_length(input logic [tns_pkg::CFG_W-1:0] raw);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_ranks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= raw;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_length(raw);
    endtask

    // scores bunched low for plenty of ties, plus the extremes and full range
    function automatic tns_pkg::t_word pick_score();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) begin
            return $urandom_range(15);
        end else if (roll < 55) begin
            case ($urandom_range(3))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hFFFF_FFFE;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // straight after reset: sixteen empty ranks
    task automatic test_empty_readout();
        send_readout();
    endtask

    // short list of four: extreme keys and scores, ties in arrival order,
    // a full-list drop on an equal score and a tail eviction
    task automatic test_ties_and_extremes();
        write_length(5'd4);
        send_insert(32'h0000_0000, 32'h0000_0000);
        send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_insert(32'hAAAA_5555, 32'd5);
        send_insert(32'h5555_AAAA, 32'd5);
        send_insert(32'h0000_00C0, 32'h0000_0000);
        send_insert(32'h0000_00D0, 32'd5);
        send_request(tns_pkg::MODE_READOUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // length saturation at both ends, and a shrink that loses entries
    // which do not come back once the list grows again
    task automatic test_length_limits();
        write_length(5'd0);
        send_readout();
        write_length(5'd31);
        send_insert(32'h1234_5678, 32'h8000_0000);
        send_insert(32'h8765_4321, 32'h7FFF_FFFF);
        send_readout();
        write_length(5'd2);
        write_length(5'd17);
        send_readout();
        write_length(5'd1);
        send_insert(32'hCAFE_0001, 32'h0000_0001);
        write_length(5'd16);
        send_readout();
    endtask

    // phases of random traffic under varied list lengths; mostly inserts so
    // the list fills and starts dropping, readouts sprinkled in between
    task automatic test_random_traffic();
        int unsigned               phase;
        int unsigned               n;
        int unsigned               pick;
        logic [tns_pkg::CFG_W-1:0] raw;
        for (phase = 0; phase < 10; phase++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: pick = $urandom_range(1, 4);
                4, 5:       pick = $urandom_range(5, 16);
                6:          pick = 0;
                7:          pick = $urandom_range(17, 31);
                default:    pick = $urandom;
            endcase
            raw = pick[tns_pkg::CFG_W-1:0];
            write_length(raw);
            // one phase runs flat out on both sides
            no_idle = (phase == 6);
            for (n = 0; n < 40; n++) begin
                if ($urandom_range(99) < 15) begin
                    send_readout();
                end else begin
                    send_insert($urandom, pick_score());
                end
            end
            no_idle = 1'b0;
        end
        send_readout();
    endtask

    initial begin
        int unsigned guard;
        shadow_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_readout();
        test_ties_and_extremes();
        test_length_limits();
        test_random_traffic();

        // drain: let the last ranks through, then a settling wait
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        guard = 0;
        while (owed_ranks.size() != 0 && guard < 100_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (owed_ranks.size() != 0) begin
            $error("%0d ranks never delivered", owed_ranks.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
